/* rtl/core/isoesc_pkg.sv */
// ----------------------------------------------------------------------------
// isoesc_pkg: shared types and constants of the shift-code escaper
// Byte codes of the escape sequences and shift codes, the character index
// limit, and the result group that travels from the scanner to the output.
// ----------------------------------------------------------------------------
package isoesc_pkg;

  localparam int IDX_W      = 12;
  localparam int LINE_CHARS = 4096;
  localparam logic [IDX_W-1:0] IDX_LIMIT =
      IDX_W'((LINE_CHARS - 1) < 4095 ? (LINE_CHARS - 1) : 4095);

  // escape sequence bytes
  localparam logic [7:0] ESC     = 8'h1B;
  localparam logic [7:0] DOLLAR  = 8'h24;
  localparam logic [7:0] LPAREN  = 8'h28;
  localparam logic [7:0] FINAL_B = 8'h42;

  // shift codes and their substitutes
  localparam logic [7:0] SO     = 8'h0E;
  localparam logic [7:0] SI     = 8'h0F;
  localparam logic [7:0] SO_SUB = 8'h19;
  localparam logic [7:0] SI_SUB = 8'h1A;

  // group queue between scanner and output
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]       data;
    logic             shift;
    logic [IDX_W-1:0] idx;
    logic             last;
  } item_t;

  // up to three result items caused by one input byte
  typedef struct packed {
    logic [1:0]      num;
    item_t [2:0]     items;
  } group_t;

endpackage

/* rtl/core/isoesc_front.sv */
// ----------------------------------------------------------------------------
// isoesc_front: byte scanner
// Take one byte per cycle unless q_full, track the charset, hold back partial
// escape sequences and turn each byte into a group of up to three results.
// ----------------------------------------------------------------------------
module isoesc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              in_line_end,
  input  logic              q_full,
  output logic              wr_en,
  output isoesc_pkg::group_t wr_group
);
  import isoesc_pkg::*;

  logic             jis_r, jis_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       held_r [2];
  logic [7:0]       held_nxt [2];
  logic [1:0]       held_cnt_r, held_cnt_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  logic             take;
  logic [7:0]       sbuf [4];
  item_t            slot [4];
  logic [1:0]       k;
  logic [1:0]       len;
  logic [1:0]       pos;
  logic [1:0]       rem;
  logic [7:0]       c;
  logic [7:0]       s1;
  logic             done;
  logic             mt0, mt1, mt2, prefix;

  function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
    sat_inc = (v < IDX_LIMIT) ? v + IDX_W'(1) : v;
  endfunction

  function automatic item_t mk_item(input logic [7:0] d, input logic s,
                                    input logic [IDX_W-1:0] i);
    item_t t;
    t.data  = d;
    t.shift = s;
    t.idx   = i;
    t.last  = 1'b0;
    mk_item = t;
  endfunction

  assign take = push && !q_full;

  always_comb begin
    jis_nxt      = jis_r;
    pend_nxt     = pend_r;
    held_nxt[0]  = held_r[0];
    held_nxt[1]  = held_r[1];
    held_cnt_nxt = held_cnt_r;
    cnt_nxt      = cnt_r;
    for (int j = 0; j < 4; j++) begin
      slot[j] = '0;
      sbuf[j] = 8'h00;
    end
    k      = 2'd0;
    len    = 2'd1;
    pos    = 2'd0;
    rem    = 2'd0;
    c      = 8'h00;
    s1     = 8'h00;
    done   = 1'b0;
    mt0    = 1'b0;
    mt1    = 1'b0;
    mt2    = 1'b0;
    prefix = 1'b0;

    if (pend_r) begin
      // second byte of a JIS pair: pass it with the pair's index
      slot[0]  = mk_item(in_byte, 1'b0, cnt_nxt);
      k        = 2'd1;
      cnt_nxt  = sat_inc(cnt_nxt);
      pend_nxt = 1'b0;
    end else begin
      unique case (held_cnt_r)
        2'd0: begin
          sbuf[0] = in_byte;
          len     = 2'd1;
        end
        2'd1: begin
          sbuf[0] = held_r[0];
          sbuf[1] = in_byte;
          len     = 2'd2;
        end
        default: begin
          sbuf[0] = held_r[0];
          sbuf[1] = held_r[1];
          sbuf[2] = in_byte;
          len     = 2'd3;
        end
      endcase
      held_cnt_nxt = 2'd0;

      for (int it = 0; it < 3; it++) begin
        if (!done && pos < len) begin
          rem    = len - pos;
          c      = sbuf[pos];
          s1     = jis_nxt ? LPAREN : DOLLAR;
          mt0    = (c == ESC);
          mt1    = (rem > 2'd1) && (sbuf[pos + 2'd1] == s1);
          mt2    = (rem > 2'd2) && (sbuf[pos + 2'd2] == FINAL_B);
          prefix = (rem == 2'd1) ? mt0 : ((rem == 2'd2) ? (mt0 && mt1) : 1'b0);
          if (mt0 && mt1 && mt2) begin
            // full sequence leaving the current set: pass it through
            slot[k]         = mk_item(sbuf[pos], 1'b0, cnt_nxt);
            slot[k + 2'd1]  = mk_item(sbuf[pos + 2'd1], 1'b0, cnt_nxt);
            slot[k + 2'd2]  = mk_item(sbuf[pos + 2'd2], 1'b0, cnt_nxt);
            k               = k + 2'd3;
            jis_nxt         = !jis_nxt;
            pos             = pos + 2'd3;
          end else if (prefix && !in_line_end) begin
            // possible start of a sequence: hold it back
            held_nxt[0]  = sbuf[pos];
            held_nxt[1]  = sbuf[pos + 2'd1];
            held_cnt_nxt = rem;
            done         = 1'b1;
          end else if (c == SO || c == SI) begin
            slot[k] = mk_item((c == SO) ? SO_SUB : SI_SUB, 1'b1, cnt_nxt);
            k       = k + 2'd1;
            cnt_nxt = sat_inc(cnt_nxt);
            pos     = pos + 2'd1;
          end else if (!jis_nxt) begin
            slot[k] = mk_item(c, 1'b0, cnt_nxt);
            k       = k + 2'd1;
            cnt_nxt = sat_inc(cnt_nxt);
            pos     = pos + 2'd1;
          end else if ((pos + 2'd1) < len) begin
            slot[k]        = mk_item(c, 1'b0, cnt_nxt);
            slot[k + 2'd1] = mk_item(sbuf[pos + 2'd1], 1'b0, cnt_nxt);
            k              = k + 2'd2;
            cnt_nxt        = sat_inc(cnt_nxt);
            pos            = pos + 2'd2;
          end else if (in_line_end) begin
            // lone trailing JIS byte: pass it uncounted
            slot[k] = mk_item(c, 1'b0, cnt_nxt);
            k       = k + 2'd1;
            pos     = pos + 2'd1;
          end else begin
            slot[k]  = mk_item(c, 1'b0, cnt_nxt);
            k        = k + 2'd1;
            pend_nxt = 1'b1;
            pos      = pos + 2'd1;
          end
        end
      end
    end

    if (in_line_end) begin
      if (k != 2'd0) begin
        slot[k - 2'd1].last = 1'b1;
      end
      // next line starts from a clean state
      jis_nxt      = 1'b0;
      pend_nxt     = 1'b0;
      held_cnt_nxt = 2'd0;
      cnt_nxt      = '0;
    end
  end

  assign wr_en          = take && (k != 2'd0);
  assign wr_group.num   = k;
  assign wr_group.items = {slot[2], slot[1], slot[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jis_r      <= 1'b0;
      pend_r     <= 1'b0;
      held_cnt_r <= 2'd0;
      cnt_r      <= '0;
    end else if (take) begin
      jis_r      <= jis_nxt;
      pend_r     <= pend_nxt;
      held_cnt_r <= held_cnt_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
    end
  end

endmodule

/* rtl/core/isoesc_queue.sv */
// ----------------------------------------------------------------------------
// isoesc_queue: result group queue
// Short queue of result groups between the scanner and the output side.
// ----------------------------------------------------------------------------
module isoesc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  isoesc_pkg::group_t wr_group,
  input  logic               rd_en,
  output isoesc_pkg::group_t rd_group,
  output logic               q_full,
  output logic               q_empty
);
  import isoesc_pkg::*;

  group_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign q_full   = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty  = (cnt_r == '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && !q_empty;
  assign rd_group = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = do_rd ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_group;
    end
  end

endmodule

/* rtl/core/isoesc_back.sv */
// ----------------------------------------------------------------------------
// isoesc_back: result serializer
// Walk the items of the head group, one result per transfer, and release
// the group after its last item.
// ----------------------------------------------------------------------------
module isoesc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  isoesc_pkg::group_t           rd_group,
  input  logic                         q_empty,
  input  logic                         pop,
  output logic                         rd_en,
  output logic                         empty,
  output logic [7:0]                   out_byte,
  output logic                         out_is_shift_code,
  output logic [isoesc_pkg::IDX_W-1:0] out_char_index,
  output logic                         out_line_last
);
  import isoesc_pkg::*;

  logic [1:0] sub_r, sub_nxt;
  item_t      cur;
  logic       xfer;
  logic       grp_done;

  assign empty    = q_empty;
  assign cur      = rd_group.items[sub_r];
  assign xfer     = pop && !q_empty;
  assign grp_done = (sub_r == (rd_group.num - 2'd1));
  assign rd_en    = xfer && grp_done;

  assign out_byte          = cur.data;
  assign out_is_shift_code = cur.shift;
  assign out_char_index    = cur.idx;
  assign out_line_last     = cur.last;

  always_comb begin
    sub_nxt = sub_r;
    if (xfer) begin
      sub_nxt = grp_done ? 2'd0 : sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 2'd0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

/* rtl/core/iso2022jp_shift_code_escaper_unit.sv */
// ----------------------------------------------------------------------------
// iso2022jp_shift_code_escaper_unit: ISO-2022-JP shift-code escaper
// Scans one line of ISO-2022-JP bytes and replaces shift codes.
// ----------------------------------------------------------------------------
// The block takes one raw byte per clock while full is low and returns the
// escaped line one byte per transfer, in input order. Bytes 0x0E and 0x0F
// at a character start come out as 0x19 and 0x1A with out_is_shift_code
// set; every other byte, escape sequences included, passes unchanged.
// out_char_index gives the character index (saturating), and out_line_last
// marks the final result byte of a line; the byte flagged by in_line_end
// closes the line and resets all scan state. When a byte is taken, the
// scanner resolves it against at most two held-back escape bytes and writes
// the results it causes (none, one, two or three) as one group into a
// four-group queue. The output side hands out one result per transfer, so
// the sustained rate is one byte per cycle in and out while pop stays high.
// A result is registered in the group queue when the byte that completes it
// is taken; the first bytes of a possible escape sequence wait until the
// byte that settles them arrives. full rises only when the group queue
// holds four groups, i.e. when results are not being popped.
// ----------------------------------------------------------------------------
module iso2022jp_shift_code_escaper_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_byte,
  input  logic                         in_line_end,
  // result channel
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         out_is_shift_code,
  output logic [isoesc_pkg::IDX_W-1:0] out_char_index,
  output logic                         out_line_last
);
  import isoesc_pkg::*;

  logic   wr_en;
  group_t wr_group;
  logic   rd_en;
  group_t rd_group;
  logic   q_full;
  logic   q_empty;

  // hold input while the group queue is full
  assign full = q_full;

  // scanner: classify each byte, advance charset, counter and hold state
  isoesc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_byte     (in_byte),
    .in_line_end (in_line_end),
    .q_full      (q_full),
    .wr_en       (wr_en),
    .wr_group    (wr_group)
  );

  // decouple scanner and output side
  isoesc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_group (wr_group),
    .rd_en    (rd_en),
    .rd_group (rd_group),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  // output side: one result per transfer, drop the group after its last item
  isoesc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rd_group          (rd_group),
    .q_empty           (q_empty),
    .pop               (pop),
    .rd_en             (rd_en),
    .empty             (empty),
    .out_byte          (out_byte),
    .out_is_shift_code (out_is_shift_code),
    .out_char_index    (out_char_index),
    .out_line_last     (out_line_last)
  );

endmodule

/* rtl/core/isoesc_checker.sv */
// ----------------------------------------------------------------------------
// isoesc_checker: port-level checks of the shift-code escaper
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module isoesc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [7:0]                   out_byte,
  input logic                         out_is_shift_code,
  input logic [isoesc_pkg::IDX_W-1:0] out_char_index,
  input logic                         out_line_last
);
  import isoesc_pkg::*;

  // a waiting result holds until it is transferred
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_char_index)
                          && $stable(out_is_shift_code) && $stable(out_line_last)))
    else $error("waiting result changed before transfer");

  // flagged results carry a substitute code only
  a_subst: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_shift_code) |-> (out_byte == SO_SUB || out_byte == SI_SUB))
    else $error("shift-code result without substitute byte");

  // index never exceeds the saturation limit
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_char_index <= IDX_LIMIT))
    else $error("character index above limit");

  // reset drains the result side
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("results visible after reset");

endmodule

bind iso2022jp_shift_code_escaper_unit isoesc_checker u_isoesc_checker (.*);

/* tb/sv/isoesc_stream_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isoesc_stream_checker: scoreboard of the shift-code escaper
// Watches both queue ports of the escaper, runs its own scan of every byte
// that goes in, and compares every result byte that comes out against the
// oldest predicted one. Hands the mismatch count and the backlog to the top.
// ----------------------------------------------------------------------------
module isoesc_stream_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  logic [7:0]                   in_byte,
  input  logic                         in_line_end,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [7:0]                   out_byte,
  input  logic                         out_is_shift_code,
  input  logic [isoesc_pkg::IDX_W-1:0] out_char_index,
  input  logic                         out_line_last,
  output int                           fail_count,
  output int                           n_waiting
);
  import isoesc_pkg::*;

  // scan state, kept apart from the block
  logic             in_jis;
  logic             pair_open;
  logic [7:0]       held [2];
  int               held_cnt;
  logic [IDX_W-1:0] char_cnt;

  item_t            escaped_q [$];
  item_t            want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_scan();
    in_jis    = 1'b0;
    pair_open = 1'b0;
    held_cnt  = 0;
    char_cnt  = '0;
  endtask

  task automatic bump_count();
    if (char_cnt < IDX_LIMIT) char_cnt++;
  endtask

  function automatic item_t mk_item(input logic [7:0] d, input logic sh,
                                    input logic [IDX_W-1:0] ix);
    item_t it;
    it.data  = d;
    it.shift = sh;
    it.idx   = ix;
    it.last  = 1'b0;
    return it;
  endfunction

  // Scan one accepted byte together with any held escape bytes.
  task automatic scan_byte(input logic [7:0] b, input logic le);
    logic [7:0] scan_q [3];
    logic [7:0] seq [3];
    logic [7:0] c;
    item_t      res [3];
    int         len, pos, rem, m, k, i;
    bit         parked;
    k = 0;
    if (pair_open) begin
      res[k] = mk_item(b, 1'b0, char_cnt);
      k++;
      bump_count();
      pair_open = 1'b0;
    end else begin
      len = 0;
      for (i = 0; i < held_cnt; i++) begin
        scan_q[len] = held[i];
        len++;
      end
      scan_q[len] = b;
      len++;
      held_cnt = 0;
      pos      = 0;
      parked   = 1'b0;
      while (pos < len && !parked) begin
        // only the sequence that leaves the current set counts
        seq[0] = ESC;
        seq[1] = in_jis ? LPAREN : DOLLAR;
        seq[2] = FINAL_B;
        rem = len - pos;
        m   = 0;
        c   = scan_q[pos];
        while (m < rem && m < 3 && scan_q[pos + m] == seq[m]) m++;
        if (m == 3) begin
          for (i = 0; i < 3; i++) begin
            res[k] = mk_item(scan_q[pos + i], 1'b0, char_cnt);
            k++;
          end
          in_jis = !in_jis;
          pos += 3;
        end else if (m == rem && !le) begin
          for (i = 0; i < rem; i++) held[i] = scan_q[pos + i];
          held_cnt = rem;
          parked   = 1'b1;
        end else if (c == SO || c == SI) begin
          res[k] = mk_item((c == SO) ? SO_SUB : SI_SUB, 1'b1, char_cnt);
          k++;
          bump_count();
          pos++;
        end else if (!in_jis) begin
          res[k] = mk_item(c, 1'b0, char_cnt);
          k++;
          bump_count();
          pos++;
        end else if (pos + 1 < len) begin
          res[k]     = mk_item(c, 1'b0, char_cnt);
          res[k + 1] = mk_item(scan_q[pos + 1], 1'b0, char_cnt);
          k += 2;
          bump_count();
          pos += 2;
        end else begin
          // lone JIS byte: uncounted at line end, else wait for its partner
          res[k] = mk_item(c, 1'b0, char_cnt);
          k++;
          if (!le) pair_open = 1'b1;
          pos++;
        end
      end
    end
    if (le) begin
      if (k > 0) res[k - 1].last = 1'b1;
      clear_scan();
    end
    for (i = 0; i < k; i++) escaped_q = {escaped_q, res[i]};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      escaped_q.delete();
    end else begin
      if (pop && !empty) begin
        if (escaped_q.size() == 0) begin
          report_mismatch($sformatf("result %02h with nothing predicted", out_byte));
        end else begin
          want = escaped_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (out_is_shift_code !== want.shift)
            report_mismatch($sformatf("out_is_shift_code %b, want %b",
                                      out_is_shift_code, want.shift));
          if (out_char_index !== want.idx)
            report_mismatch($sformatf("out_char_index %0d, want %0d",
                                      out_char_index, want.idx));
          if (out_line_last !== want.last)
            report_mismatch($sformatf("out_line_last %b, want %b",
                                      out_line_last, want.last));
        end
      end
      if (push && !full) scan_byte(in_byte, in_line_end);
    end
    n_waiting = escaped_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the ISO-2022-JP shift-code escaper
// Feeds directed lines (shift codes, escape sequences in both directions,
// broken and truncated sequences) and then random lines through the
// escaper with random gaps on both queue ports. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import isoesc_pkg::*;

  localparam int N_RANDOM_BYTES = 114;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic [7:0]       in_byte;
  logic             in_line_end;
  logic             empty;
  logic             pop;
  logic [7:0]       out_byte;
  logic             out_is_shift_code;
  logic [IDX_W-1:0] out_char_index;
  logic             out_line_last;

  int               fail_count;
  int               n_waiting;
  int               idle_cycles;
  int               n_random;
  bit               steady_in;
  bit               steady_out;
  logic [7:0]       line_q [$];

  iso2022jp_shift_code_escaper_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_line_end       (in_line_end),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_is_shift_code (out_is_shift_code),
    .out_char_index    (out_char_index),
    .out_line_last     (out_line_last)
  );

  isoesc_stream_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_line_end       (in_line_end),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_is_shift_code (out_is_shift_code),
    .out_char_index    (out_char_index),
    .out_line_last     (out_line_last),
    .fail_count        (fail_count),
    .n_waiting         (n_waiting)
  );

  // 20 ns clock, low phase first
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Append one byte to the line under construction.
  task automatic append_byte(input logic [7:0] b);
    line_q = {line_q, b};
  endtask

  // Present one byte at a falling edge and hold it until the transfer
  // happens; then, at the next falling edge, optionally drop push for a gap.
  task automatic send_byte(input logic [7:0] b, input logic le);
    int gap;
    push        <= 1'b1;
    in_byte     <= b;
    in_line_end <= le;
    do @(posedge clk); while (full);
    @(negedge clk);
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Send the assembled line, flagging its final byte as the line end.
  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Build a mostly well-formed random line: characters of the current set,
  // set switches, shift codes, escapes of the wrong direction, cut-off
  // escapes and raw noise. Occasionally cut the last byte off.
  task automatic build_random_line();
    int n_tok, t, sel;
    bit jis;
    jis   = 1'b0;
    n_tok = $urandom_range(1, 14);
    for (t = 0; t < n_tok; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        if (jis) begin
          append_byte(8'($urandom_range(8'h21, 8'h7E)));
          append_byte(8'($urandom_range(8'h21, 8'h7E)));
        end else begin
          append_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
      end else if (sel < 45) begin
        append_byte(ESC);
        append_byte(jis ? LPAREN : DOLLAR);
        append_byte(FINAL_B);
        jis = !jis;
      end else if (sel < 55) begin
        append_byte($urandom_range(0, 1) ? SO : SI);
      end else if (sel < 63) begin
        append_byte(ESC);
        append_byte(jis ? DOLLAR : LPAREN);
        append_byte(FINAL_B);
      end else if (sel < 73) begin
        append_byte(ESC);
        if ($urandom_range(0, 1)) append_byte(jis ? LPAREN : DOLLAR);
      end else if (sel < 82) begin
        append_byte(ESC);
        append_byte(8'($urandom_range(0, 255)));
      end else begin
        append_byte(8'($urandom_range(0, 255)));
      end
    end
    if (line_q.size() > 1 && $urandom_range(0, 9) == 0) line_q.delete(line_q.size() - 1);
  endtask

  // Result side: pop with random stalls, switching now and then into a
  // stretch without any stall.
  initial begin : drain
    int stall;
    int cyc;
    stall = 0;
    cyc   = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) steady_out = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = steady_out ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("iso2022jp_shift_code_escaper_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    push        = 1'b0;
    in_byte     = 8'h00;
    in_line_end = 1'b0;
    pop         = 1'b0;
    rst_n       = 1'b0;
    steady_in   = 1'b0;
    steady_out  = 1'b0;
    idle_cycles = 0;
    n_random    = 0;

    // hold reset, then release it at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed lines ---
    // single-byte line with the lowest byte
    line_q = '{8'h00};
    send_line();
    // top byte, shift codes in ASCII, switch to JIS, a pair, a shift code
    // inside JIS, a pair whose second byte is ESC, switch back
    line_q = '{8'hFF, SO, SI, ESC, DOLLAR, FINAL_B, 8'h30, 8'h21, SO,
               8'h30, ESC, ESC, LPAREN, FINAL_B, FINAL_B};
    send_line();
    // cut-off escape at the line end: flush as ordinary bytes
    line_q = '{ESC, DOLLAR};
    send_line();
    // lone trailing JIS byte
    line_q = '{ESC, DOLLAR, FINAL_B, 8'h30};
    send_line();
    // broken escape: rescan the held bytes
    line_q = '{ESC, ESC, DOLLAR, FINAL_B, ESC, ESC, DOLLAR, ESC, LPAREN, FINAL_B};
    send_line();
    // wrong-direction escape in ASCII is plain text
    line_q = '{ESC, LPAREN, FINAL_B, 8'h7F};
    send_line();

    // --- random lines ---
    while (n_random < N_RANDOM_BYTES) begin
      steady_in = ($urandom_range(0, 4) == 0);
      build_random_line();
      n_random += line_q.size();
      send_line();
    end
    push        <= 1'b0;
    in_line_end <= 1'b0;

    // drain: wait for every predicted result, then watch for strays
    wait (n_waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("iso2022jp_shift_code_escaper_unit verification clean");
    end else begin
      $display("iso2022jp_shift_code_escaper_unit verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/isoesc_pkg.sv
rtl/core/isoesc_front.sv
rtl/core/isoesc_queue.sv
rtl/core/isoesc_back.sv
rtl/core/iso2022jp_shift_code_escaper_unit.sv
rtl/core/isoesc_checker.sv
tb/sv/isoesc_stream_checker.sv
tb/sv/tb_top.sv
